>>> rtl/core/tri_rast_pkg.sv
package tri_rast_pkg;

   // Fixed widths of the register and result fields.
   localparam int DIM_REG_W = 13;
   localparam int PIXEL_W   = 12;
   localparam int COLOR_W   = 32;

   // Image size after reset.
   localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd200;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Request modes.
   typedef enum logic [0:0] {
      MODE_LOAD    = 1'b0,
      MODE_ADVANCE = 1'b1
   } req_mode_type;

endpackage

>>> rtl/core/triangle_bbox_edge_rasterizer.sv
// Triangle rasterizer: bounding box scan with an edge function for each triangle edge.
//
// Request channel (req_valid / req_stall): a load transaction (mode 0)
// latches three vertices and a fill color, clamps their bounding box to the
// image and starts a scan when the box is not empty; it returns nothing.
// Each advance transaction (mode 1) tests the current pixel, returns one
// response and steps the scan, x outer and y inner. An advance while no scan
// is running is taken and dropped.
// Response channel (rsp_valid / rsp_stall): pixel position, coverage, color
// and a flag on the last pixel of the box.
// rsp_valid rises in the cycle after an accepted advance of a running scan.
// One transaction is accepted every cycle while req_stall is low. The path
// from the scan registers through the edge multipliers and sign test into
// the response register is combinational. While rsp_stall holds a waiting
// response, req_stall is raised and the response register keeps its value.
// The csr port writes image width and height; a write takes effect at the
// next load. Reset clears the scan and the response valid flag and sets the
// image size to 200 by 200.
module triangle_bbox_edge_rasterizer
   import tri_rast_pkg::*;
#(
   parameter int MAX_DIM    = 4096,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_write_enable,
   input  logic [0:0]                   csr_index,
   input  logic [DIM_REG_W-1:0]         csr_write_data,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic signed [COORD_BITS-1:0] req_x0,
   input  logic signed [COORD_BITS-1:0] req_y0,
   input  logic signed [COORD_BITS-1:0] req_x1,
   input  logic signed [COORD_BITS-1:0] req_y1,
   input  logic signed [COORD_BITS-1:0] req_x2,
   input  logic signed [COORD_BITS-1:0] req_y2,
   input  logic [COLOR_W-1:0]           req_color,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PIXEL_W-1:0]           rsp_pixel_x,
   output logic [PIXEL_W-1:0]           rsp_pixel_y,
   output logic                         rsp_covered,
   output logic [COLOR_W-1:0]           rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   // Pixel coordinates hold values up to MAX_DIM-1.
   localparam int PIX_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PIX_EXT_W = (PIX_BITS > PIXEL_W) ? PIX_BITS : PIXEL_W;
   // Signed width for the clamp; wider than coordinates and image limits.
   localparam int CMP_MAX   = (COORD_BITS > PIX_BITS + 2) ? COORD_BITS :
                              ((PIX_BITS + 2 > DIM_REG_W + 2) ? PIX_BITS + 2 : DIM_REG_W + 2);
   localparam int CMP_W     = CMP_MAX + 1;
   // Edge arithmetic widths.
   localparam int D_W       = COORD_BITS + 1;
   localparam int P_W       = ((PIX_BITS + 1 > COORD_BITS) ? PIX_BITS + 1 : COORD_BITS) + 1;
   localparam int PROD_W    = D_W + P_W;
   localparam int E_W       = PROD_W + 1;

   localparam logic signed [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
   localparam logic signed [CMP_W-1:0] ONE_C     = CMP_W'(1);
   localparam logic signed [CMP_W-1:0] ZERO_C    = '0;

   // Configuration registers.
   logic [DIM_REG_W-1:0] image_width_ff, image_width_in;
   logic [DIM_REG_W-1:0] image_height_ff, image_height_in;

   // Triangle and scan state.
   logic signed [COORD_BITS-1:0] vx_ff [3];
   logic signed [COORD_BITS-1:0] vy_ff [3];
   logic signed [D_W-1:0]        dx_ff [3];
   logic signed [D_W-1:0]        dy_ff [3];
   logic [COLOR_W-1:0]           fill_color_ff;
   logic [PIX_BITS-1:0]          box_min_x_ff, box_min_y_ff;
   logic [PIX_BITS-1:0]          box_max_x_ff, box_max_y_ff;
   logic [PIX_BITS-1:0]          scan_x_ff, scan_x_in;
   logic [PIX_BITS-1:0]          scan_y_ff, scan_y_in;
   logic                         scan_active_ff, scan_active_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic                rsp_covered_ff, rsp_last_pixel_ff;
   logic [COLOR_W-1:0]  rsp_pixel_color_ff;

   logic req_fire;
   logic load_fire;
   logic adv_fire;
   logic produce;
   logic is_last;

   function automatic logic signed [CMP_W-1:0] smin(input logic signed [CMP_W-1:0] a,
                                                    input logic signed [CMP_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [CMP_W-1:0] smax(input logic signed [CMP_W-1:0] a,
                                                    input logic signed [CMP_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [CMP_W-1:0] cext(input logic signed [COORD_BITS-1:0] v);
      return {{(CMP_W-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   // Handshake: take a transaction unless a finished response is held back.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign load_fire = req_fire & (req_mode == MODE_LOAD);
   assign adv_fire  = req_fire & (req_mode == MODE_ADVANCE);
   assign produce   = adv_fire & scan_active_ff;

   // Configuration writes.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            REG_IMAGE_HEIGHT: image_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= DIM_RESET;
         image_height_ff <= DIM_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // Bounding box of the incoming triangle, clamped to the image.
   logic signed [CMP_W-1:0] width_ext, height_ext;
   logic signed [CMP_W-1:0] lim_x, lim_y;
   logic signed [CMP_W-1:0] lo_x, hi_x, lo_y, hi_y;
   logic signed [CMP_W-1:0] bmin_x, bmax_x, bmin_y, bmax_y;
   logic                    box_ok;

   always_comb begin
      width_ext  = {{(CMP_W-DIM_REG_W){1'b0}}, image_width_ff};
      height_ext = {{(CMP_W-DIM_REG_W){1'b0}}, image_height_ff};
      lim_x = ((width_ext > MAX_DIM_C) ? MAX_DIM_C : width_ext) - ONE_C;
      lim_y = ((height_ext > MAX_DIM_C) ? MAX_DIM_C : height_ext) - ONE_C;
      lo_x = smin(cext(req_x0), smin(cext(req_x1), cext(req_x2)));
      hi_x = smax(cext(req_x0), smax(cext(req_x1), cext(req_x2)));
      lo_y = smin(cext(req_y0), smin(cext(req_y1), cext(req_y2)));
      hi_y = smax(cext(req_y0), smax(cext(req_y1), cext(req_y2)));
      bmin_x = smax(ZERO_C, smin(lim_x, lo_x));
      bmax_x = smin(lim_x, smax(ZERO_C, hi_x));
      bmin_y = smax(ZERO_C, smin(lim_y, lo_y));
      bmax_y = smin(lim_y, smax(ZERO_C, hi_y));
      box_ok = (bmin_x <= bmax_x) && (bmin_y <= bmax_y);
   end

   // Triangle registers, written on a load.
   always_ff @(posedge clock) begin
      if (load_fire) begin
         vx_ff[0] <= req_x0;
         vx_ff[1] <= req_x1;
         vx_ff[2] <= req_x2;
         vy_ff[0] <= req_y0;
         vy_ff[1] <= req_y1;
         vy_ff[2] <= req_y2;
         dx_ff[0] <= D_W'(req_x0) - D_W'(req_x1);
         dx_ff[1] <= D_W'(req_x1) - D_W'(req_x2);
         dx_ff[2] <= D_W'(req_x2) - D_W'(req_x0);
         dy_ff[0] <= D_W'(req_y0) - D_W'(req_y1);
         dy_ff[1] <= D_W'(req_y1) - D_W'(req_y2);
         dy_ff[2] <= D_W'(req_y2) - D_W'(req_y0);
         fill_color_ff <= req_color;
         box_min_x_ff  <= bmin_x[PIX_BITS-1:0];
         box_max_x_ff  <= bmax_x[PIX_BITS-1:0];
         box_min_y_ff  <= bmin_y[PIX_BITS-1:0];
         box_max_y_ff  <= bmax_y[PIX_BITS-1:0];
      end
   end

   // Scan stepping: y inner, x outer.
   assign is_last = (scan_x_ff == box_max_x_ff) && (scan_y_ff == box_max_y_ff);

   always_comb begin
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      scan_active_in = scan_active_ff;
      if (load_fire) begin
         scan_x_in      = bmin_x[PIX_BITS-1:0];
         scan_y_in      = bmin_y[PIX_BITS-1:0];
         scan_active_in = box_ok;
      end else if (produce) begin
         if (is_last) begin
            scan_active_in = 1'b0;
         end else if (scan_y_ff < box_max_y_ff) begin
            scan_y_in = scan_y_ff + PIX_BITS'(1);
         end else begin
            scan_y_in = box_min_y_ff;
            scan_x_in = scan_x_ff + PIX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
      end else begin
         scan_active_ff <= scan_active_in;
      end
      scan_x_ff <= scan_x_in;
      scan_y_ff <= scan_y_in;
   end

   // Edge functions at the current pixel, one per triangle edge.
   logic signed [P_W-1:0] px_s, py_s;
   logic [2:0]            edge_pos, edge_neg;
   logic                  covered;

   assign px_s = {{(P_W-PIX_BITS){1'b0}}, scan_x_ff};
   assign py_s = {{(P_W-PIX_BITS){1'b0}}, scan_y_ff};

   for (genvar k = 0; k < 3; k++) begin : g_edge
      logic signed [P_W-1:0]    ax, ay;
      logic signed [P_W-1:0]    ddx, ddy;
      logic signed [PROD_W-1:0] prod_a, prod_b;
      logic signed [E_W-1:0]    edge_val;

      assign ax       = {{(P_W-COORD_BITS){vx_ff[k][COORD_BITS-1]}}, vx_ff[k]};
      assign ay       = {{(P_W-COORD_BITS){vy_ff[k][COORD_BITS-1]}}, vy_ff[k]};
      assign ddy      = py_s - ay;
      assign ddx      = px_s - ax;
      assign prod_a   = dx_ff[k] * ddy;
      assign prod_b   = dy_ff[k] * ddx;
      assign edge_val = E_W'(prod_a) - E_W'(prod_b);
      assign edge_pos[k] = ~edge_val[E_W-1] & (edge_val != '0);
      assign edge_neg[k] = edge_val[E_W-1];
   end

   assign covered = (&edge_pos) | (&edge_neg);

   // Response register.
   logic [PIX_EXT_W-1:0] px_wide, py_wide;

   assign px_wide      = PIX_EXT_W'(scan_x_ff);
   assign py_wide      = PIX_EXT_W'(scan_y_ff);
   assign rsp_valid_in = produce | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (produce) begin
         rsp_pixel_x_ff     <= px_wide[PIXEL_W-1:0];
         rsp_pixel_y_ff     <= py_wide[PIXEL_W-1:0];
         rsp_covered_ff     <= covered;
         rsp_pixel_color_ff <= fill_color_ff;
         rsp_last_pixel_ff  <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_pixel_x_ff;
   assign rsp_pixel_y     = rsp_pixel_y_ff;
   assign rsp_covered     = rsp_covered_ff;
   assign rsp_pixel_color = rsp_pixel_color_ff;
   assign rsp_last_pixel  = rsp_last_pixel_ff;

`ifndef SYNTHESIS
   // A running scan never leaves its latched box.
   assert property (@(posedge clock) disable iff (reset)
      scan_active_ff |-> (scan_x_ff >= box_min_x_ff) && (scan_x_ff <= box_max_x_ff) &&
                         (scan_y_ff >= box_min_y_ff) && (scan_y_ff <= box_max_y_ff))
      else $error("scan position outside bounding box");

   // An advance while idle creates no response.
   assert property (@(posedge clock) disable iff (reset)
      (adv_fire && !scan_active_ff) |=> rsp_valid_ff == ($past(rsp_valid_ff) && $past(rsp_stall)))
      else $error("idle advance produced a response");

   // Requests are held back only behind a waiting response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled without a waiting response");

   // The last pixel ends the scan.
   assert property (@(posedge clock) disable iff (reset)
      (produce && is_last) |=> !scan_active_ff)
      else $error("scan still running after its last pixel");
`endif

endmodule
